// ===== rtl/psch_pkg.sv =====
// Shared types and codes for the priority task scheduler.
// Used by psch_ctrl, psch_dp and the top level; depends on nothing.
`timescale 1ns / 1ps
package psch_pkg;

  typedef enum logic [2:0] {
    REQ_CREATE  = 3'd0,
    REQ_DELAY   = 3'd1,
    REQ_SUSPEND = 3'd2,
    REQ_RESUME  = 3'd3,
    REQ_TICK    = 3'd4,
    REQ_RESCHED = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    MODE_FREE      = 2'd0,
    MODE_READY     = 2'd1,
    MODE_DELAYED   = 2'd2,
    MODE_SUSPENDED = 2'd3
  } mode_e;

  typedef struct packed {
    logic ld_req;
    logic ld_id;
    logic ld_cur;
    logic apply;
    logic scan_clr;
    logic scan_step;
    logic pick_init;
    logic pick_step;
    logic ld_out;
  } dp_cmd_t;

  typedef struct packed {
    logic do_pick;
    logic scan_last;
    logic mask_empty;
    logic pick_done;
  } dp_sts_t;

endpackage

// ===== rtl/psch_ctrl.sv =====
// Sequencer of the priority task scheduler: steps one request through
// lookup, update, table scan, task pick and result. Depends on psch_pkg.
`timescale 1ns / 1ps
module psch_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  psch_pkg::dp_sts_t sts_i,
  output psch_pkg::dp_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RID   = 3'd1;
  localparam logic [2:0] S_RCUR  = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_PSEL  = 3'd5;
  localparam logic [2:0] S_PICK  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_vld_q, out_vld_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_req = 1'b1;
          state_d      = S_RID;
        end
      end
      S_RID: begin
        cmd_o.ld_id = 1'b1;
        state_d     = S_RCUR;
      end
      S_RCUR: begin
        cmd_o.ld_cur = 1'b1;
        state_d      = S_APPLY;
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        if (sts_i.do_pick) begin
          cmd_o.scan_clr = 1'b1;
          state_d        = S_SCAN;
        end else begin
          state_d = S_OUT;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = S_PSEL;
      end
      S_PSEL: begin
        cmd_o.pick_init = 1'b1;
        state_d = sts_i.mask_empty ? S_OUT : S_PICK;
      end
      S_PICK: begin
        cmd_o.pick_step = 1'b1;
        if (sts_i.pick_done) state_d = S_OUT;
      end
      S_OUT: begin
        // The result word waits here only while the previous one is unread.
        if (!out_vld_q || out_ready_i) begin
          cmd_o.ld_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_ready_i) out_vld_d = 1'b0;
    if (cmd_o.ld_out) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;

endmodule

// ===== rtl/psch_dp.sv =====
// Datapath of the priority task scheduler: task table, wake time memory,
// round-robin cursors, tick counter and result register. Depends on psch_pkg.
`timescale 1ns / 1ps
module psch_dp #(
  parameter int MAX_TASKS      = 16,
  parameter int NUM_PRIORITIES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  psch_pkg::dp_cmd_t cmd_i,
  output psch_pkg::dp_sts_t sts_o,
  input  logic [2:0]        req_type_i,
  input  logic [3:0]        task_id_i,
  input  logic              use_current_i,
  input  logic [2:0]        task_priority_i,
  input  logic [31:0]       delay_ticks_i,
  output logic [3:0]        running_task_o,
  output logic              switched_o,
  output logic              status_o
);

  localparam int AW = $clog2(MAX_TASKS);
  localparam int PW = $clog2(NUM_PRIORITIES);
  localparam int CW = AW + 1;

  function automatic logic [AW-1:0] nxt_slot(input logic [AW-1:0] s);
    nxt_slot = (s == AW'(MAX_TASKS - 1)) ? '0 : s + AW'(1);
  endfunction

  // Request word.
  logic [2:0]  req_q;
  logic [3:0]  id_q;
  logic        usecur_q;
  logic [2:0]  prio_q;
  logic [31:0] ticks_q;

  // Task table and scheduler state.
  logic [1:0]    mode_q   [MAX_TASKS];
  logic [2:0]    tprio_q  [MAX_TASKS];
  logic [AW-1:0] cursor_q [NUM_PRIORITIES];
  logic [AW-1:0] cur_q;
  logic [31:0]   tick_q;
  logic          tepoch_q;
  logic [NUM_PRIORITIES-1:0] mask_q;

  // Wake time and epoch, no reset: only read for delayed tasks.
  logic [32:0]   wmem [MAX_TASKS];
  logic [32:0]   wrd_q;
  logic [AW-1:0] wraddr;

  logic [1:0]    id_mode_q, cur_mode_q;
  logic [2:0]    id_prio_q, cur_prio_q;
  logic          res_ign_q, res_sw_q;
  logic [CW-1:0] scan_cnt_q;
  logic [AW-1:0] slot_q, pcnt_q;
  logic [PW-1:0] selp_q;
  logic [3:0]    out_task_q;
  logic          out_sw_q, out_st_q;

  logic [AW+3:0] id_ext, cur_ext;
  logic          id_ok, id_is_cur;
  logic [AW-1:0] id_idx, scan_idx, tbl_idx;
  logic [CW-1:0] scan_prev;
  logic          scan_act;
  logic [1:0]    mode_rd;
  logic [2:0]    prio_rd;

  logic          ign, do_pick, wr_en, tgt_cur, wr_prio, wr_wake;
  logic [1:0]    wr_mode;
  logic [32:0]   wsum;
  logic          woken;
  logic [NUM_PRIORITIES-1:0] mask_set;
  logic [PW-1:0] top_p;
  logic          hit, plast;

  assign id_ext    = {{AW{1'b0}}, id_q};
  assign cur_ext   = {4'b0000, cur_q};
  assign id_ok     = id_ext < (AW + 4)'(MAX_TASKS);
  assign id_idx    = id_ok ? id_ext[AW-1:0] : '0;
  assign id_is_cur = (id_ext == cur_ext);
  assign scan_prev = scan_cnt_q - CW'(1);
  assign scan_act  = (scan_cnt_q != '0);
  assign scan_idx  = scan_act ? scan_prev[AW-1:0] : '0;

  // Decision for the request, from the looked-up target and running task.
  always_comb begin
    ign     = 1'b0;
    do_pick = 1'b0;
    wr_en   = 1'b0;
    wr_mode = psch_pkg::MODE_FREE;
    tgt_cur = 1'b0;
    wr_prio = 1'b0;
    wr_wake = 1'b0;
    unique case (req_q)
      psch_pkg::REQ_CREATE: begin
        if (id_q == 4'd0 || !id_ok || id_mode_q != psch_pkg::MODE_FREE ||
            {5'b0, prio_q} >= 8'(NUM_PRIORITIES)) begin
          ign = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_mode = psch_pkg::MODE_READY;
          wr_prio = 1'b1;
        end
      end
      psch_pkg::REQ_DELAY: begin
        if (cur_mode_q != psch_pkg::MODE_READY) begin
          ign = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_mode = psch_pkg::MODE_DELAYED;
          tgt_cur = 1'b1;
          wr_wake = 1'b1;
          do_pick = 1'b1;
        end
      end
      psch_pkg::REQ_SUSPEND: begin
        if (usecur_q || id_is_cur) begin
          wr_en   = 1'b1;
          wr_mode = psch_pkg::MODE_SUSPENDED;
          tgt_cur = 1'b1;
          do_pick = 1'b1;
        end else if (!id_ok || id_mode_q == psch_pkg::MODE_FREE) begin
          ign = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_mode = psch_pkg::MODE_SUSPENDED;
        end
      end
      psch_pkg::REQ_RESUME: begin
        if (!id_ok || id_mode_q == psch_pkg::MODE_FREE || id_is_cur) begin
          ign = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_mode = psch_pkg::MODE_READY;
          do_pick = (id_prio_q > cur_prio_q);
        end
      end
      psch_pkg::REQ_TICK:    do_pick = 1'b1;
      psch_pkg::REQ_RESCHED: do_pick = 1'b1;
      default:               ign = 1'b1;
    endcase
  end

  // One table port, steered by whichever step is active.
  always_comb begin
    if (cmd_i.ld_id)          tbl_idx = id_idx;
    else if (cmd_i.apply)     tbl_idx = tgt_cur ? cur_q : id_idx;
    else if (cmd_i.scan_step) tbl_idx = scan_idx;
    else if (cmd_i.pick_step) tbl_idx = slot_q;
    else                      tbl_idx = cur_q;
  end

  assign mode_rd = mode_q[tbl_idx];
  assign prio_rd = tprio_q[tbl_idx];
  assign wsum    = {1'b0, tick_q} + {1'b0, ticks_q};
  assign wraddr  = (scan_cnt_q < CW'(MAX_TASKS)) ? scan_cnt_q[AW-1:0] : '0;

  // The scan reads the wake word in the cycle before it processes that slot.
  assign woken = cmd_i.scan_step && scan_act && (req_q == psch_pkg::REQ_TICK) &&
                 (mode_rd == psch_pkg::MODE_DELAYED) && (wrd_q[32] == tepoch_q) &&
                 (wrd_q[31:0] <= tick_q);

  always_comb begin
    mask_set = '0;
    for (int p = 0; p < NUM_PRIORITIES; p++) begin
      if ({5'b0, prio_rd} == 8'(p)) mask_set[p] = 1'b1;
    end
  end

  always_comb begin
    top_p = '0;
    for (int p = 0; p < NUM_PRIORITIES; p++) begin
      if (mask_q[p]) top_p = PW'(p);
    end
  end

  assign hit   = (mode_rd == psch_pkg::MODE_READY) && ({5'b0, prio_rd} == 8'(selp_q));
  assign plast = (pcnt_q == AW'(MAX_TASKS - 1));

  assign sts_o.do_pick    = do_pick;
  assign sts_o.scan_last  = (scan_cnt_q == CW'(MAX_TASKS));
  assign sts_o.mask_empty = (mask_q == '0);
  assign sts_o.pick_done  = hit || plast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        mode_q[i]  <= (i == 0) ? psch_pkg::MODE_READY : psch_pkg::MODE_FREE;
        tprio_q[i] <= '0;
      end
      for (int p = 0; p < NUM_PRIORITIES; p++) cursor_q[p] <= '0;
      cur_q      <= '0;
      tick_q     <= '0;
      tepoch_q   <= 1'b0;
      mask_q     <= '0;
      scan_cnt_q <= '0;
    end else begin
      if (cmd_i.apply) begin
        if (wr_en) mode_q[tbl_idx] <= wr_mode;
        if (wr_prio) tprio_q[tbl_idx] <= prio_q;
        if (req_q == psch_pkg::REQ_TICK) begin
          tick_q <= tick_q + 32'd1;
          if (tick_q == '1) tepoch_q <= ~tepoch_q;
        end
      end
      if (cmd_i.scan_clr) begin
        scan_cnt_q <= '0;
        mask_q     <= '0;
      end
      if (cmd_i.scan_step) begin
        scan_cnt_q <= scan_cnt_q + CW'(1);
        if (woken) mode_q[tbl_idx] <= psch_pkg::MODE_READY;
        if (scan_act && (woken || mode_rd == psch_pkg::MODE_READY)) begin
          mask_q <= mask_q | mask_set;
        end
      end
      if (cmd_i.pick_init && mask_q == '0) cur_q <= '0;
      if (cmd_i.pick_step) begin
        if (hit) begin
          cur_q            <= slot_q;
          cursor_q[selp_q] <= slot_q;
        end else if (plast) begin
          cur_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_req) begin
      req_q    <= req_type_i;
      id_q     <= task_id_i;
      usecur_q <= use_current_i;
      prio_q   <= task_priority_i;
      ticks_q  <= delay_ticks_i;
    end
    if (cmd_i.ld_id) begin
      id_mode_q <= mode_rd;
      id_prio_q <= prio_rd;
    end
    if (cmd_i.ld_cur) begin
      cur_mode_q <= mode_rd;
      cur_prio_q <= prio_rd;
    end
    if (cmd_i.apply) begin
      res_ign_q <= ign;
      res_sw_q  <= do_pick;
    end
    if (cmd_i.apply && wr_wake) wmem[cur_q] <= {tepoch_q ^ wsum[32], wsum[31:0]};
    wrd_q <= wmem[wraddr];
    if (cmd_i.pick_init) begin
      selp_q <= top_p;
      slot_q <= nxt_slot(cursor_q[top_p]);
      pcnt_q <= '0;
    end
    if (cmd_i.pick_step) begin
      slot_q <= nxt_slot(slot_q);
      pcnt_q <= pcnt_q + AW'(1);
    end
    if (cmd_i.ld_out) begin
      out_task_q <= cur_ext[3:0];
      out_sw_q   <= res_sw_q;
      out_st_q   <= res_ign_q;
    end
  end

  assign running_task_o = out_task_q;
  assign switched_o     = out_sw_q;
  assign status_o       = out_st_q;

endmodule

// ===== rtl/priority_task_scheduler.sv =====
// Top level of the priority task scheduler: stream ports around the
// sequencer (psch_ctrl) and the datapath (psch_dp). Depends on psch_pkg.
// Requests that pick no task go through lookup, update and result; those
// that do add a full table scan, then a round-robin search of up to
// MAX_TASKS slots, one slot per cycle.
// One request at a time: the next word is taken only once the result is loaded.
// Reset is asynchronous, active low: task 0 ready, all other tasks free, priorities, cursors and tick cleared.
`timescale 1ns / 1ps
module priority_task_scheduler #(
  parameter int MAX_TASKS      = 16,
  parameter int NUM_PRIORITIES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [3:0] task_id, [4] use_current, [7:5] task_priority, [39:8] delay_ticks
  input  logic [39:0] s_axis_tdata_i,
  // [2:0] req_type
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [3:0] running_task, [4] switched, [5] status, [7:6] zero
  output logic [7:0]  m_axis_tdata_o
);

  psch_pkg::dp_cmd_t cmd;
  psch_pkg::dp_sts_t sts;
  logic [3:0]        running_task;
  logic              switched, status;

  psch_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  psch_dp #(
    .MAX_TASKS      (MAX_TASKS),
    .NUM_PRIORITIES (NUM_PRIORITIES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (s_axis_tuser_i),
    .task_id_i       (s_axis_tdata_i[3:0]),
    .use_current_i   (s_axis_tdata_i[4]),
    .task_priority_i (s_axis_tdata_i[7:5]),
    .delay_ticks_i   (s_axis_tdata_i[39:8]),
    .running_task_o  (running_task),
    .switched_o      (switched),
    .status_o        (status)
  );

  assign m_axis_tdata_o = {2'b00, status, switched, running_task};

endmodule

// ===== rtl/psch_chk.sv =====
// Port-level checker for the priority task scheduler, bound to the top level.
// Depends on priority_task_scheduler.
`timescale 1ns / 1ps
module psch_chk #(
  parameter int MAX_TASKS = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  // An ignored request never reports a switch.
  a_ign_no_sw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[5] && m_axis_tdata_o[4]))
    else $error("ignored request reported a switch");

  // Requests are worked one at a time.
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while a request is in work");

  // The running task is always a real slot.
  a_task_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ({28'd0, m_axis_tdata_o[3:0]} < 32'(MAX_TASKS)))
    else $error("running task outside the task table");

endmodule

bind priority_task_scheduler psch_chk #(.MAX_TASKS(MAX_TASKS)) u_psch_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
